@@ sv/fipm_pkg.sv @@
`default_nettype none
package fipm_pkg;

  localparam int PAT_W     = 64;  // pattern register width
  localparam int WID_W     = 7;   // pattern width register
  localparam int THR_W     = 16;  // threshold, Q4.12
  localparam int FRAC_W    = 12;  // fraction bits of the threshold
  localparam int RUN_W     = 7;   // one expected run, also run count
  localparam int LEN_W     = 6;   // exact pattern length
  localparam int LZ_W      = 6;   // leading zeroes
  localparam int SUM_OUT_W = 22;  // reported window sum
  localparam int CFG_DW    = 64;
  localparam int CFG_AW    = 5;

  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_WIDTH   = 2'd1;
  localparam logic [1:0] REG_THRESH  = 2'd2;

  localparam logic [PAT_W-1:0] PAT_RST = {PAT_W{1'b1}};
  localparam logic [WID_W-1:0] WID_RST = 7'd64;
  localparam logic [THR_W-1:0] THR_RST = 16'd819;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_TRAIL = 8'b0000_0100,
    S_IDLE  = 8'b0000_1000,
    S_SUM   = 8'b0001_0000,
    S_TOL   = 8'b0010_0000,
    S_CMP   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

@@ sv/fipm_ram.sv @@
`default_nettype none
module fipm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

@@ sv/flux_interval_pattern_matcher.sv @@
// Flux interval pattern matcher.
// Input channel (in_valid/in_ready, in_flux_interval): one measured interval per item.
// Result channel (out_valid/out_ready): one result per input item with matched,
// window_sum, intervals_used, leading_zeroes and pattern_error.
// Configuration: APB-style port, 64-bit data, registers at byte addresses 0, 8, 16.
// Every write of a register restarts run derivation: the pattern is scanned one bit
// a cycle, during which in_ready is low.
// Reset loads the reset pattern, clears the window (fill count) and runs the same
// derivation, and no item is taken until it is done.
// One item at a time: accept, a summing pass over the exact runs (one window read
// per cycle), a tolerance multiply, a compare pass over all runs through a two-stage
// multiply/compare pipeline, then the result. A pattern error gives the result in the
// cycle after accept. The result is held in its registers until taken; a stalled
// receiver simply holds the block, which takes no new item until then.
`default_nettype none
module flux_interval_pattern_matcher
  import fipm_pkg::*;
#(
  parameter int MAX_INTERVALS = 32,
  parameter int INTERVAL_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [INTERVAL_BITS-1:0] in_flux_interval,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_matched,
  output logic [SUM_OUT_W-1:0]          out_window_sum,
  output logic [RUN_W-1:0]              out_intervals_used,
  output logic [LZ_W-1:0]               out_leading_zeroes,
  output logic                          out_pattern_error,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_AW-1:0]        paddr,
  input  wire logic [CFG_DW-1:0]        pwdata,
  output logic [CFG_DW-1:0]             prdata,
  output logic                          pready
);

  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int SW = INTERVAL_BITS + CW;
  localparam int P1W = RUN_W + SW;
  localparam int P2W = INTERVAL_BITS + LEN_W;
  localparam int PW = ((P1W > P2W) ? P1W : P2W) + 1;
  localparam int TW = THR_W + SW;
  localparam int EW = PW + FRAC_W;
  localparam int XW = SW + SUM_OUT_W;

  state_t state_r, state_nxt;

  logic [PAT_W-1:0] pattern_r;
  logic [WID_W-1:0] width_r;
  logic [THR_W-1:0] thresh_r;

  // derivation
  logic [PAT_W-1:0] scan_r;
  logic [5:0]       j_r;
  logic             found_r;
  logic [5:0]       hi_r;
  logic [5:0]       prev_r;
  logic [RUN_W-1:0] runcnt_r;
  logic [LEN_W-1:0] len_r;
  logic [LZ_W-1:0]  lz_r;
  logic             trail_r;
  logic             bad_r;

  // window
  logic [AW-1:0]    wptr_r;
  logic [CW-1:0]    fill_r;

  // item processing
  logic [CW-1:0]    cnt_r;
  logic [SW-1:0]    sum_r;
  logic [TW-1:0]    tol_r;
  logic             ok_r;
  logic             rd_v_r, rd_ok_r, rd_tr_r;
  logic             pv_r, ptr_r;
  logic [P1W-1:0]   p1_r;
  logic [P2W-1:0]   p2_r;

  logic                     cfg_wr;
  logic [PAT_W-1:0]         pat_masked;
  logic                     in_acc;
  logic [AW-1:0]            wptr_next;
  logic [CW-1:0]            rc_c, exact_c, age_c, wp_ext, addr_c;
  logic                     issue;
  logic [INTERVAL_BITS-1:0] win_rdata, cval;
  logic [RUN_W-1:0]         run_rdata;
  logic                     run_we;
  logic [RUN_W-1:0]         run_wdata;
  logic                     trail_c, wbad_c;
  logic [RUN_W-1:0]         rcf_c;
  logic [WID_W-1:0]         lz_full;
  logic signed [PW-1:0]     diff_c;
  logic [PW-1:0]            mag_c;
  logic [EW-1:0]            magx_c, tolx_c;
  logic                     fail_c;
  logic [XW-1:0]            sum_x;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[4:3])
      REG_PATTERN: prdata = pattern_r;
      REG_WIDTH:   prdata = CFG_DW'(width_r);
      REG_THRESH:  prdata = CFG_DW'(thresh_r);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    for (int j = 0; j < PAT_W; j++) begin
      pat_masked[j] = pattern_r[j] & (WID_W'(j) < width_r);
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign out_valid = (state_r == S_OUT);
  assign wptr_next = (wptr_r == AW'(MAX_INTERVALS - 1)) ? '0 : wptr_r + 1'b1;

  assign rc_c    = CW'(runcnt_r);
  assign exact_c = rc_c - CW'(trail_r);
  assign issue   = ((state_r == S_SUM) && (cnt_r < exact_c)) ||
                   ((state_r == S_CMP) && (cnt_r < rc_c));

  // age 0 is the newest interval; the last run pairs with it
  assign age_c  = rc_c - CW'(1) - cnt_r;
  assign wp_ext = CW'(wptr_r);
  assign addr_c = (wp_ext >= age_c) ? wp_ext - age_c
                                    : wp_ext + CW'(MAX_INTERVALS) - age_c;

  // derivation, end of scan
  assign wbad_c  = (width_r == '0) || (width_r > WID_W'(PAT_W));
  assign trail_c = found_r && (prev_r != '0);
  assign rcf_c   = runcnt_r + RUN_W'(trail_c);
  assign lz_full = width_r - WID_W'(1) - WID_W'(hi_r);

  always_comb begin
    run_we    = 1'b0;
    run_wdata = RUN_W'(prev_r - j_r);
    if (state_r == S_SCAN) begin
      run_we = scan_r[PAT_W-1] && found_r && (runcnt_r < RUN_W'(MAX_INTERVALS));
    end else if (state_r == S_TRAIL) begin
      run_we    = trail_c && (runcnt_r < RUN_W'(MAX_INTERVALS));
      run_wdata = RUN_W'(prev_r) + RUN_W'(1);
    end
  end

  fipm_ram #(.WIDTH(INTERVAL_BITS), .DEPTH(MAX_INTERVALS)) u_win_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wptr_next),
    .wdata (in_flux_interval),
    .raddr (AW'(addr_c)),
    .rdata (win_rdata)
  );

  fipm_ram #(.WIDTH(RUN_W), .DEPTH(MAX_INTERVALS)) u_run_ram (
    .clk   (clk),
    .we    (run_we),
    .waddr (AW'(runcnt_r)),
    .wdata (run_wdata),
    .raddr (AW'(cnt_r)),
    .rdata (run_rdata)
  );

  // compare stage: |r*S - c*L| * 4096 against T*S; the trailing run fails only when r*S exceeds c*L
  assign cval   = rd_ok_r ? win_rdata : '0;
  assign diff_c = $signed(PW'(p1_r)) - $signed(PW'(p2_r));
  assign mag_c  = diff_c[PW-1] ? PW'(-diff_c) : PW'(diff_c);
  assign magx_c = {mag_c, {FRAC_W{1'b0}}};
  assign tolx_c = EW'(tol_r);
  assign fail_c = (magx_c > tolx_c) && (!ptr_r || !diff_c[PW-1]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:  state_nxt = S_SCAN;
      S_SCAN:  if (j_r == '0) state_nxt = S_TRAIL;
      S_TRAIL: state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = bad_r ? S_OUT : S_SUM;
      S_SUM:   if (cnt_r == exact_c) state_nxt = S_TOL;
      S_TOL:   state_nxt = (sum_r == '0) ? S_OUT : S_CMP;
      S_CMP:   if (cnt_r == rc_c && !rd_v_r && !pv_r) state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_LOAD;
    endcase
    if (cfg_wr && (paddr[4:3] == REG_PATTERN || paddr[4:3] == REG_WIDTH ||
                   paddr[4:3] == REG_THRESH)) begin
      state_nxt = S_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      pattern_r <= PAT_RST;
      width_r   <= WID_RST;
      thresh_r  <= THR_RST;
      wptr_r    <= AW'(MAX_INTERVALS - 1);
      fill_r    <= '0;
      bad_r     <= 1'b1;
      rd_v_r    <= 1'b0;
      pv_r      <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        case (paddr[4:3])
          REG_PATTERN: pattern_r <= pwdata;
          REG_WIDTH:   width_r   <= pwdata[WID_W-1:0];
          REG_THRESH:  thresh_r  <= pwdata[THR_W-1:0];
          default:     ;
        endcase
      end

      if (in_acc) begin
        wptr_r <= wptr_next;
        if (fill_r != CW'(MAX_INTERVALS)) fill_r <= fill_r + 1'b1;
      end

      if (state_r == S_TRAIL) begin
        bad_r <= wbad_c || !found_r || (rcf_c > RUN_W'(MAX_INTERVALS));
      end

      rd_v_r <= issue;
      pv_r   <= rd_v_r && (state_r == S_CMP);

      if (in_acc || state_r == S_TOL) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // payload and derivation data, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      S_LOAD: begin
        scan_r   <= pat_masked;
        j_r      <= 6'd63;
        found_r  <= 1'b0;
        hi_r     <= '0;
        prev_r   <= '0;
        runcnt_r <= '0;
      end
      S_SCAN: begin
        if (scan_r[PAT_W-1]) begin
          if (!found_r) begin
            found_r <= 1'b1;
            hi_r    <= j_r;
          end else begin
            runcnt_r <= runcnt_r + 1'b1;
          end
          prev_r <= j_r;
        end
        scan_r <= scan_r << 1;
        j_r    <= j_r - 1'b1;
      end
      S_TRAIL: begin
        runcnt_r <= rcf_c;
        trail_r  <= trail_c;
        len_r    <= hi_r - prev_r;
        lz_r     <= lz_full[LZ_W-1:0];
      end
      default: ;
    endcase

    rd_ok_r <= age_c < fill_r;
    rd_tr_r <= cnt_r >= exact_c;

    if (in_acc) begin
      sum_r <= '0;
      ok_r  <= ~bad_r;
    end else if (state_r == S_SUM && rd_v_r) begin
      sum_r <= sum_r + SW'(cval);
    end else if (state_r == S_TOL) begin
      tol_r <= TW'(thresh_r * sum_r);
      if (sum_r == '0) ok_r <= 1'b0;
    end else if (pv_r && fail_c) begin
      ok_r <= 1'b0;
    end

    p1_r  <= P1W'(run_rdata * sum_r);
    p2_r  <= P2W'(cval * len_r);
    ptr_r <= rd_tr_r;
  end

  assign sum_x              = XW'(sum_r);
  assign out_matched        = ok_r & ~bad_r;
  assign out_window_sum     = bad_r ? '0 : sum_x[SUM_OUT_W-1:0];
  assign out_intervals_used = bad_r ? '0 : runcnt_r;
  assign out_leading_zeroes = bad_r ? '0 : lz_r;
  assign out_pattern_error  = bad_r;

endmodule
`default_nettype wire

@@ sv/fipm_checker.sv @@
`default_nettype none
module fipm_sva
  import fipm_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 out_matched,
  input wire logic [SUM_OUT_W-1:0] out_window_sum,
  input wire logic [RUN_W-1:0]     out_intervals_used,
  input wire logic                 out_pattern_error
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched) &&
      $stable(out_window_sum) && $stable(out_intervals_used))
    else $error("result changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("ready while a result waits");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pattern_error |-> !out_matched && out_window_sum == '0 &&
      out_intervals_used == '0)
    else $error("fields set on pattern error");

  a_match_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matched |-> out_window_sum != '0 || out_intervals_used != '0)
    else $error("match with empty window");

endmodule

bind flux_interval_pattern_matcher fipm_sva u_fipm_sva (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_matched        (out_matched),
  .out_window_sum     (out_window_sum),
  .out_intervals_used (out_intervals_used),
  .out_pattern_error  (out_pattern_error)
);
`default_nettype wire

@@ tb/sv/fipm_checker.sv @@
`default_nettype none
module fipm_checker
  import fipm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic [15:0]          in_flux_interval,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic                 out_matched,
  input  wire logic [SUM_OUT_W-1:0] out_window_sum,
  input  wire logic [RUN_W-1:0]     out_intervals_used,
  input  wire logic [LZ_W-1:0]      out_leading_zeroes,
  input  wire logic                 out_pattern_error,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [CFG_AW-1:0]    paddr,
  input  wire logic [CFG_DW-1:0]    pwdata,
  input  wire logic                 pready,
  output int                        fail_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;

  typedef struct packed {
    logic                 matched;
    logic [SUM_OUT_W-1:0] sum;
    logic [RUN_W-1:0]     used;
    logic [LZ_W-1:0]      lz;
    logic                 perr;
  } match_result_t;

  logic [PAT_W-1:0] pat_val;
  logic [WID_W-1:0] pat_width;
  logic [THR_W-1:0] thresh;
  logic [15:0]      flux_win[DEPTH];
  int               run_len[DEPTH];
  int               n_runs, lead_z, exact_len;
  bit               has_trail, pat_bad;
  match_result_t    result_q[$];

  initial fail_count = 0;

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void add_run(input int r);
    if (n_runs < DEPTH) run_len[n_runs] = r;
    n_runs++;
  endfunction

  function automatic void derive_runs();
    int w, hi, lo, prv;
    logic [63:0] p, mask;
    for (int i = 0; i < DEPTH; i++) run_len[i] = 0;
    n_runs = 0; lead_z = 0; exact_len = 0; has_trail = 0; pat_bad = 1;
    w = pat_width;
    if (w == 0 || w > 64) return;
    mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    p = pat_val & mask;
    if (p == 0) return;
    hi = -1; lo = -1;
    for (int i = 0; i < 64; i++)
      if (p[i]) begin
        if (lo < 0) lo = i;
        hi = i;
      end
    lead_z = w - 1 - hi;
    prv = hi;
    for (int i = hi - 1; i >= lo; i--)
      if (p[i]) begin
        add_run(prv - i);
        prv = i;
      end
    exact_len = hi - lo;
    if (lo > 0) begin
      has_trail = 1;
      add_run(lo + 1);
    end
    pat_bad = n_runs > DEPTH;
  endfunction

  function automatic match_result_t predict_match(input logic [15:0] flux);
    match_result_t r;
    int start, exact;
    longint sum, tol, d, e, mag;
    bit ok;
    for (int i = 0; i + 1 < DEPTH; i++) flux_win[i] = flux_win[i+1];
    flux_win[DEPTH-1] = flux;
    r = '0;
    r.perr = pat_bad;
    if (pat_bad) return r;
    start = DEPTH - n_runs;
    exact = n_runs - (has_trail ? 1 : 0);
    sum = 0;
    for (int i = 0; i < exact; i++) sum += flux_win[start+i];
    ok = sum != 0;
    tol = longint'(thresh) * sum;
    for (int i = 0; ok && i < n_runs; i++) begin
      d = longint'(run_len[i]) * sum - longint'(flux_win[start+i]) * exact_len;
      e = d * 4096;
      if (i < exact) begin
        mag = (e < 0) ? -e : e;
        if (mag > tol) ok = 0;
      end else if (e > 0 && e > tol) ok = 0;
    end
    r.matched = ok;
    r.sum = sum[SUM_OUT_W-1:0];
    r.used = n_runs[RUN_W-1:0];
    r.lz = lead_z[LZ_W-1:0];
    return r;
  endfunction

  function automatic void load_reset();
    pat_val = PAT_RST;
    pat_width = WID_RST;
    thresh = THR_RST;
    for (int i = 0; i < DEPTH; i++) flux_win[i] = '0;
    derive_runs();
  endfunction

  initial load_reset();

  always @(posedge clk) begin
    match_result_t got, want;
    if (!rst_n) begin
      load_reset();
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_PATTERN: begin pat_val = pwdata; derive_runs(); end
          REG_WIDTH:   begin pat_width = pwdata[WID_W-1:0]; derive_runs(); end
          REG_THRESH:  begin thresh = pwdata[THR_W-1:0]; derive_runs(); end
          default: ;
        endcase
      end
      if (in_valid && in_ready) result_q = {result_q, predict_match(in_flux_interval)};
      if (out_valid && out_ready) begin
        got = '{out_matched, out_window_sum, out_intervals_used,
                out_leading_zeroes, out_pattern_error};
        if (result_q.size() == 0) report("result with no item outstanding");
        else begin
          want = result_q.pop_front();
          if (got.matched !== want.matched)
            report($sformatf("matched got %0b want %0b", got.matched, want.matched));
          if (got.sum !== want.sum)
            report($sformatf("window_sum got %0d want %0d", got.sum, want.sum));
          if (got.used !== want.used)
            report($sformatf("intervals_used got %0d want %0d", got.used, want.used));
          if (got.lz !== want.lz)
            report($sformatf("leading_zeroes got %0d want %0d", got.lz, want.lz));
          if (got.perr !== want.perr)
            report($sformatf("pattern_error got %0b want %0b", got.perr, want.perr));
        end
      end
    end
    pending <= result_q.size();
  end

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none
module tb;
  import fipm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 0, rst_n = 0;
  logic                 in_valid = 0, in_ready;
  logic [15:0]          in_flux_interval = '0;
  logic                 out_valid, out_ready = 0;
  logic                 out_matched, out_pattern_error;
  logic [SUM_OUT_W-1:0] out_window_sum;
  logic [RUN_W-1:0]     out_intervals_used;
  logic [LZ_W-1:0]      out_leading_zeroes;
  logic                 psel = 0, penable = 0, pwrite = 0, pready;
  logic [CFG_AW-1:0]    paddr = '0;
  logic [CFG_DW-1:0]    pwdata = '0, prdata;
  int                   fail_count, pending;
  int                   gap_max = 16, stall_max = 16, stall = 0, idle_cycles = 0;

  always #5 clk = ~clk;

  flux_interval_pattern_matcher dut (.*);

  fipm_checker chk (.*);

  // result side stall, redrawn after each taken item
  always @(posedge clk) begin
    if (out_valid && out_ready) stall = $urandom_range(0, stall_max);
    else if (stall > 0) stall--;
  end
  always @(negedge clk) out_ready <= (stall == 0);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles = 0;
    else if (++idle_cycles >= 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_flux(input logic [15:0] v);
    int g;
    g = $urandom_range(0, gap_max);
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_flux_interval <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_pattern(input logic [63:0] p, input logic [6:0] w);
    drain();
    cfg_write(REG_PATTERN, p);
    cfg_write(REG_WIDTH, {57'd0, w});
  endtask

  initial begin
    int n, tz, lz, pos, u, sent, jit, mode;
    int runs[8];
    logic [63:0] p;
    logic [6:0] w;
    repeat (2) @(negedge clk);
    rst_n <= 1;

    // reset pattern is unusable
    send_flux(16'd0);
    send_flux(16'hFFFF);
    // single one bit: no exact runs, sum is zero
    set_pattern(64'h1, 7'd1);
    send_flux(16'd100);
    send_flux(16'd100);
    set_pattern(64'h1, 7'd0);
    send_flux(16'd5);
    set_pattern(64'h1, 7'd100);
    send_flux(16'd5);
    // all ones: 32 runs fit, 33 do not
    set_pattern('1, 7'd33);
    for (int i = 0; i < 33; i++) send_flux(16'd50);
    set_pattern('1, 7'd34);
    send_flux(16'd50);
    // no one bit inside the width, bits above it set
    set_pattern(64'hF0, 7'd4);
    send_flux(16'd7);
    drain();
    cfg_write(2'd3, 64'h1234);
    // trailing run, checked one-sidedly
    set_pattern(64'b1001000, 7'd9);
    send_flux(16'd300); send_flux(16'd400); send_flux(16'd900);
    send_flux(16'd300); send_flux(16'd200);

    for (int ph = 0; ph < 12; ph++) begin
      n = $urandom_range(1, 6);
      tz = $urandom_range(0, 3);
      lz = $urandom_range(0, 5);
      pos = tz;
      p = 64'd1 << pos;
      for (int i = n - 1; i >= 0; i--) begin
        runs[i] = $urandom_range(1, 5);
        pos += runs[i];
        p[pos] = 1;
      end
      w = 7'(pos + 1 + lz);
      if (ph % 3 == 1) p |= {$urandom, $urandom} << w;
      drain();
      case (ph % 4)
        0: cfg_write(REG_THRESH, 64'd0);
        1: cfg_write(REG_THRESH, 64'd65535);
        2: cfg_write(REG_THRESH, {48'd0, 16'($urandom)});
        default: cfg_write(REG_THRESH, 64'd819);
      endcase
      cfg_write(REG_PATTERN, p);
      cfg_write(REG_WIDTH, {57'd0, w});
      gap_max = (ph % 4 == 3) ? 0 : 16;
      stall_max = (ph % 4 == 3) ? 0 : 16;
      sent = 0;
      while (sent < 40) begin
        mode = $urandom_range(0, 9);
        if (mode < 8) begin
          u = $urandom_range(4, 2000);
          for (int i = 0; i < n; i++) begin
            jit = (mode < 4) ? 0 : $urandom_range(0, u / 8) - u / 16;
            send_flux(16'(runs[i] * u + jit));
            sent++;
          end
          if (tz > 0) begin
            send_flux(16'((tz + 1) * u + $urandom_range(0, u) - (mode == 7 ? u : 0)));
            sent++;
          end
        end else begin
          send_flux((mode == 9 && sent % 2) ? 16'hFFFF : 16'($urandom));
          sent++;
        end
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
